/* rtl/hfa_pkg.sv */
// Package for the truncating binary16 adder: field widths and constants.
// Used by every module of the adder; depends on nothing.
package hfa_pkg;
  localparam int unsigned FracW = 10;
  localparam int unsigned ExpW  = 5;
  localparam int unsigned SigW  = 11;
  localparam logic [ExpW-1:0] ExpMax = 5'h1f;

  typedef struct packed {
    logic            sign;
    logic [ExpW-1:0] expo;
    logic [SigW-1:0] sig;
  } hfa_op_t;
endpackage

/* rtl/half_float_adder_truncating.sv */
// Truncating binary16 adder, three register stages: align, add, normalise.
// Each accepted request passes the align, add and normalise registers in turn before the done strobe.
// Throughput is one request per cycle; busy is never raised and results cannot stall.
// Reset clears the stage valid bits only; no result is pending after reset.
// Depends on hfa_pkg, hfa_align, hfa_addsub and hfa_norm.
module half_float_adder_truncating import hfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  output logic        done,
  output logic [15:0] sum_bits_o
);
  logic v1, byp1, sub1, ssgn1, v2, byp2, sub2, sgn2;
  logic [15:0] bb1, bb2;
  hfa_op_t big1;
  logic [SigW-1:0] ssig1;
  logic [ExpW-1:0] exp2;
  logic [SigW:0] sum2;

  assign busy = 1'b0;

  hfa_align u_align (
    .clk_i, .rst_ni, .valid_i(start & ~busy), .operand_a_i, .operand_b_i,
    .valid_o(v1), .bypass_o(byp1), .bypass_bits_o(bb1), .eff_sub_o(sub1),
    .big_o(big1), .small_sig_o(ssig1), .small_sign_o(ssgn1)
  );

  hfa_addsub u_addsub (
    .clk_i, .rst_ni, .valid_i(v1), .bypass_i(byp1), .bypass_bits_i(bb1),
    .eff_sub_i(sub1), .big_i(big1), .small_sig_i(ssig1), .small_sign_i(ssgn1),
    .valid_o(v2), .bypass_o(byp2), .bypass_bits_o(bb2), .eff_sub_o(sub2),
    .sign_o(sgn2), .expo_o(exp2), .sum_o(sum2)
  );

  hfa_norm u_norm (
    .clk_i, .rst_ni, .valid_i(v2), .bypass_i(byp2), .bypass_bits_i(bb2),
    .eff_sub_i(sub2), .sign_i(sgn2), .expo_i(exp2), .sum_i(sum2),
    .valid_o(done), .sum_bits_o
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##3 done) else $error("request did not complete in three cycles");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> $past(start, 3)) else $error("result without a request");
  a_add_magnitude: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2 && !sub2 && !byp2 |-> sum2[SigW] || sum2[SigW-1])
    else $error("same-sign sum lost its leading bit");
`endif
endmodule

/* rtl/hfa_align.sv */
// First stage: unpacks both operands, orders them and aligns the smaller one.
// Depends on hfa_pkg.
module hfa_align import hfa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [15:0]         operand_a_i,
  input  logic [15:0]         operand_b_i,
  output logic                valid_o,
  output logic                bypass_o,
  output logic [15:0]         bypass_bits_o,
  output logic                eff_sub_o,
  output hfa_op_t             big_o,
  output logic [SigW-1:0]     small_sig_o,
  output logic                small_sign_o
);
  logic valid_q, bypass_q, eff_sub_q, small_sign_q;
  logic [15:0] bypass_bits_q, bypass_bits_d;
  hfa_op_t big_q, big_d;
  logic [SigW-1:0] small_sig_q, small_sig_d;
  logic small_sign_d, bypass_d;
  logic [ExpW-1:0] ea, eb, shift_amt;
  logic [SigW-1:0] ma, mb, ms;
  logic a_big;

  always_comb begin
    ea = operand_a_i[14:10];
    eb = operand_b_i[14:10];
    ma = {1'b1, operand_a_i[9:0]};
    mb = {1'b1, operand_b_i[9:0]};
    a_big = (ea > eb);
    bypass_d = (ea == '0) || (eb == '0);
    if (ea == '0 && eb == '0) begin
      bypass_bits_d = {operand_a_i[15] & operand_b_i[15], 15'd0};
    end else if (ea == '0) begin
      bypass_bits_d = operand_b_i;
    end else begin
      bypass_bits_d = operand_a_i;
    end
    if (a_big) begin
      big_d = '{sign: operand_a_i[15], expo: ea, sig: ma};
      ms = mb;
      shift_amt = ea - eb;
      small_sign_d = operand_b_i[15];
    end else begin
      big_d = '{sign: operand_b_i[15], expo: eb, sig: mb};
      ms = ma;
      shift_amt = eb - ea;
      small_sign_d = operand_a_i[15];
    end
    small_sig_d = (shift_amt > 5'd11) ? '0 : (ms >> shift_amt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bypass_q      <= bypass_d;
    bypass_bits_q <= bypass_bits_d;
    eff_sub_q     <= operand_a_i[15] ^ operand_b_i[15];
    big_q         <= big_d;
    small_sig_q   <= small_sig_d;
    small_sign_q  <= small_sign_d;
  end

  assign valid_o       = valid_q;
  assign bypass_o      = bypass_q;
  assign bypass_bits_o = bypass_bits_q;
  assign eff_sub_o     = eff_sub_q;
  assign big_o         = big_q;
  assign small_sig_o   = small_sig_q;
  assign small_sign_o  = small_sign_q;
endmodule

/* rtl/hfa_addsub.sv */
// Second stage: adds or subtracts the aligned significands.
// Depends on hfa_pkg.
module hfa_addsub import hfa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic            bypass_i,
  input  logic [15:0]     bypass_bits_i,
  input  logic            eff_sub_i,
  input  hfa_op_t         big_i,
  input  logic [SigW-1:0] small_sig_i,
  input  logic            small_sign_i,
  output logic            valid_o,
  output logic            bypass_o,
  output logic [15:0]     bypass_bits_o,
  output logic            eff_sub_o,
  output logic            sign_o,
  output logic [ExpW-1:0] expo_o,
  output logic [SigW:0]   sum_o
);
  logic valid_q, bypass_q, eff_sub_q, sign_q;
  logic [15:0] bypass_bits_q;
  logic [ExpW-1:0] expo_q;
  logic [SigW:0] sum_q, sum_d;
  logic sign_d;

  always_comb begin
    sign_d = big_i.sign;
    if (!eff_sub_i) begin
      sum_d = {1'b0, big_i.sig} + {1'b0, small_sig_i};
    end else if (big_i.sig >= small_sig_i) begin
      sum_d = {1'b0, big_i.sig - small_sig_i};
    end else begin
      sum_d = {1'b0, small_sig_i - big_i.sig};
      sign_d = small_sign_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bypass_q      <= bypass_i;
    bypass_bits_q <= bypass_bits_i;
    eff_sub_q     <= eff_sub_i;
    sign_q        <= sign_d;
    expo_q        <= big_i.expo;
    sum_q         <= sum_d;
  end

  assign valid_o       = valid_q;
  assign bypass_o      = bypass_q;
  assign bypass_bits_o = bypass_bits_q;
  assign eff_sub_o     = eff_sub_q;
  assign sign_o        = sign_q;
  assign expo_o        = expo_q;
  assign sum_o         = sum_q;
endmodule

/* rtl/hfa_norm.sv */
// Third stage: normalises the sum, handles overflow, underflow and cancellation.
// Depends on hfa_pkg.
module hfa_norm import hfa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic            bypass_i,
  input  logic [15:0]     bypass_bits_i,
  input  logic            eff_sub_i,
  input  logic            sign_i,
  input  logic [ExpW-1:0] expo_i,
  input  logic [SigW:0]   sum_i,
  output logic            valid_o,
  output logic [15:0]     sum_bits_o
);
  logic valid_q;
  logic [15:0] res_q, res_d;
  logic [3:0] lz;
  logic [SigW-1:0] nsig;
  logic [ExpW:0] e;

  always_comb begin
    lz = 4'd11;
    for (int i = 0; i < SigW; i++) begin
      if (sum_i[i]) lz = 4'(SigW - 1 - i);
    end
    nsig = sum_i[SigW-1:0] << lz;
    e = {1'b0, expo_i};
    if (bypass_i) begin
      res_d = bypass_bits_i;
    end else if (!eff_sub_i) begin
      if (sum_i[SigW]) begin
        e = e + 6'd1;
        nsig = sum_i[SigW:1];
      end else begin
        nsig = sum_i[SigW-1:0];
      end
      res_d = (e >= {1'b0, ExpMax}) ? {sign_i, ExpMax, 10'd0}
                                     : {sign_i, e[ExpW-1:0], nsig[FracW-1:0]};
    end else if (sum_i == '0) begin
      res_d = '0;
    end else if ({2'b0, lz} >= e) begin
      res_d = {sign_i, 15'd0};
    end else begin
      e = e - {2'b0, lz};
      res_d = (e >= {1'b0, ExpMax}) ? {sign_i, ExpMax, 10'd0}
                                     : {sign_i, e[ExpW-1:0], nsig[FracW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o    = valid_q;
  assign sum_bits_o = res_q;
endmodule
